>>> rtl/core/lcabl_pkg.sv
// Shared types and constants of the binary-lifting LCA engine.
package lcabl_pkg;

  localparam int unsigned NODE_W     = 6;
  localparam int unsigned DEPTH_W    = 7;
  localparam int unsigned DIST_W     = 7;
  localparam int unsigned SUM_W      = DEPTH_W + 1;
  // Level counter; holds every level index and the level count (up to 15)
  localparam int unsigned LVL_W      = 4;

  localparam int unsigned NODES_DEF  = 64;
  localparam int unsigned LEVELS_DEF = 7;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 7'd127;
  localparam logic [DIST_W-1:0]  DIST_MAX  = 7'd126;

  typedef enum logic [1:0] {
    MODE_ROOT   = 2'd0,
    MODE_ATTACH = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } lca_req_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic [DIST_W-1:0] distance;
  } lca_res_t;

  // Read addresses, issued every cycle
  typedef struct packed {
    logic [NODE_W-1:0] tbl_node0;
    logic [NODE_W-1:0] tbl_node1;
    logic [LVL_W-1:0]  tbl_lvl;
    logic [NODE_W-1:0] dep_node0;
    logic [NODE_W-1:0] dep_node1;
  } lcabl_rd_t;

  // Read data, already masked by the node valid bits
  typedef struct packed {
    logic [NODE_W-1:0]  tbl0;
    logic [NODE_W-1:0]  tbl1;
    logic [DEPTH_W-1:0] dep0;
    logic [DEPTH_W-1:0] dep1;
  } lcabl_rdata_t;

  typedef struct packed {
    logic               tbl_we;
    logic [NODE_W-1:0]  tbl_node;
    logic [LVL_W-1:0]   tbl_lvl;
    logic [NODE_W-1:0]  tbl_data;
    logic               dep_we;
    logic [NODE_W-1:0]  dep_node;
    logic [DEPTH_W-1:0] dep_data;
    logic               vld_set;
    logic               vld_clr;
    logic [NODE_W-1:0]  vld_node;
  } lcabl_wr_t;

endpackage

>>> rtl/core/lca_binary_lifting_engine.sv
// Top level: binary-lifting lowest common ancestor engine.
// Set root writes the node into every level; clear acts from idle;
// attach writes the depth and level 0, then each higher level in turn;
// a query lifts the deeper node, descends the levels and reads the
// ancestor depth. One transaction at a time (busy high); the table
// memory has registered reads. Reset clears node valid bits at once; no
// clearing pass. The result strobe lasts one cycle and cannot be stalled.
module lca_binary_lifting_engine #(
  parameter int unsigned NODES  = lcabl_pkg::NODES_DEF,
  parameter int unsigned LEVELS = lcabl_pkg::LEVELS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  lcabl_pkg::lca_req_t req_i,
  output logic                res_valid_o,
  output lcabl_pkg::lca_res_t res_o
);

  localparam int unsigned NODE_W  = lcabl_pkg::NODE_W;
  localparam int unsigned DEPTH_W = lcabl_pkg::DEPTH_W;
  localparam int unsigned SUM_W   = lcabl_pkg::SUM_W;
  localparam int unsigned LVL_W   = lcabl_pkg::LVL_W;

  localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVELS - 1);
  localparam logic [LVL_W-1:0] LVL_CNT  = LVL_W'(LEVELS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT,      // write node as its own ancestor, one level per cycle
    S_AT_DEP,    // parent depth back; write depth and level 0
    S_AT_RD,     // read ancestor of level-1 ancestor
    S_AT_WR,     // write level entry
    S_Q_DEP,     // both depths back; order nodes
    S_Q_LIFT,    // lift deeper node by depth difference
    S_Q_LIFTW,
    S_Q_CMP,
    S_Q_DESC,    // descend levels from the top
    S_Q_DESCW,
    S_Q_FIN,     // final step to the shared parent
    S_Q_FINW,
    S_Q_ANC,     // read ancestor depth
    S_Q_OUT
  } state_e;

  state_e                  state_q;
  logic [NODE_W-1:0]       a_q, b_q, x_q, y_q, anc_q;
  logic [DEPTH_W-1:0]      dt_q;
  logic [SUM_W-1:0]        sum_q;
  logic [LVL_W-1:0]        lvl_q;
  logic                    res_valid_q;
  lcabl_pkg::lca_res_t     res_q;

  lcabl_pkg::lcabl_rd_t    rd;
  lcabl_pkg::lcabl_wr_t    wr;
  lcabl_pkg::lcabl_rdata_t rdat;

  logic accept, a_ok, b_ok, dt_bit;
  logic [SUM_W-1:0]   par_dep, twice, diff;
  logic [DEPTH_W-1:0] new_dep;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign a_ok   = 32'(req_i.node_a) < NODES;
  assign b_ok   = 32'(req_i.node_b) < NODES;
  assign dt_bit = |(dt_q & (DEPTH_W'(1) << lvl_q));

  // attach depth saturates at the top code
  assign par_dep = SUM_W'(rdat.dep1) + SUM_W'(1);
  assign new_dep = (par_dep > SUM_W'(lcabl_pkg::DEPTH_MAX)) ? lcabl_pkg::DEPTH_MAX
                                                             : par_dep[DEPTH_W-1:0];

  // path distance from the depth sum and the ancestor depth
  assign twice = {rdat.dep0, 1'b0};
  assign diff  = sum_q - twice;

  lcabl_store #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (rd),
    .wr_i    (wr),
    .rdata_o (rdat)
  );

  // memory addressing and write strobes per state
  always_comb begin
    rd           = '0;
    wr           = '0;
    rd.dep_node0 = req_i.node_a;
    rd.dep_node1 = req_i.node_b;
    rd.tbl_node0 = x_q;
    rd.tbl_node1 = y_q;
    rd.tbl_lvl   = lvl_q;
    wr.tbl_node  = a_q;
    wr.tbl_lvl   = lvl_q;
    wr.dep_node  = a_q;
    wr.vld_node  = a_q;
    case (state_q)
      S_IDLE: begin
        wr.dep_node = req_i.node_a;
        wr.vld_node = req_i.node_a;
        wr.dep_data = DEPTH_W'(1);
        if (accept && a_ok) begin
          if (req_i.mode == lcabl_pkg::MODE_ROOT) begin
            wr.dep_we  = 1'b1;
            wr.vld_set = 1'b1;
          end else if (req_i.mode == lcabl_pkg::MODE_CLEAR) begin
            wr.vld_clr = 1'b1;
          end
        end
      end
      S_ROOT: begin
        wr.tbl_we   = 1'b1;
        wr.tbl_data = a_q;
      end
      S_AT_DEP: begin
        wr.dep_we   = 1'b1;
        wr.dep_data = new_dep;
        wr.tbl_we   = 1'b1;
        wr.tbl_lvl  = '0;
        wr.tbl_data = b_q;
        wr.vld_set  = 1'b1;
      end
      S_AT_RD: begin
        rd.tbl_lvl = lvl_q - LVL_W'(1);
      end
      S_AT_WR: begin
        wr.tbl_we   = 1'b1;
        wr.tbl_data = rdat.tbl0;
      end
      S_Q_DESC: begin
        rd.tbl_lvl = lvl_q - LVL_W'(1);
      end
      S_Q_FIN: begin
        rd.tbl_lvl = '0;
      end
      S_Q_ANC: begin
        rd.dep_node0 = anc_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      lvl_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
      x_q         <= '0;
      y_q         <= '0;
      anc_q       <= '0;
      dt_q        <= '0;
      sum_q       <= '0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          a_q   <= req_i.node_a;
          b_q   <= req_i.node_b;
          lvl_q <= '0;
          if (accept) begin
            case (req_i.mode)
              lcabl_pkg::MODE_ROOT:   if (a_ok) state_q <= S_ROOT;
              lcabl_pkg::MODE_ATTACH: if (a_ok && b_ok) state_q <= S_AT_DEP;
              lcabl_pkg::MODE_QUERY:  if (a_ok && b_ok) state_q <= S_Q_DEP;
              default: begin
              end
            endcase
          end
        end
        S_ROOT: begin
          lvl_q <= lvl_q + LVL_W'(1);
          if (lvl_q == LVL_LAST) state_q <= S_IDLE;
        end
        S_AT_DEP: begin
          x_q   <= b_q;
          lvl_q <= LVL_W'(1);
          state_q <= (LEVELS == 1) ? S_IDLE : S_AT_RD;
        end
        S_AT_RD: begin
          state_q <= S_AT_WR;
        end
        S_AT_WR: begin
          // written entry is the next hop
          x_q   <= rdat.tbl0;
          lvl_q <= lvl_q + LVL_W'(1);
          state_q <= (lvl_q == LVL_LAST) ? S_IDLE : S_AT_RD;
        end
        S_Q_DEP: begin
          sum_q <= SUM_W'(rdat.dep0) + SUM_W'(rdat.dep1);
          if (rdat.dep0 < rdat.dep1) begin
            x_q  <= b_q;
            y_q  <= a_q;
            dt_q <= rdat.dep1 - rdat.dep0;
          end else begin
            x_q  <= a_q;
            y_q  <= b_q;
            dt_q <= rdat.dep0 - rdat.dep1;
          end
          state_q <= S_Q_LIFT;
        end
        S_Q_LIFT: begin
          if (lvl_q == LVL_CNT) begin
            state_q <= S_Q_CMP;
          end else if (dt_bit) begin
            state_q <= S_Q_LIFTW;
          end else begin
            lvl_q <= lvl_q + LVL_W'(1);
          end
        end
        S_Q_LIFTW: begin
          x_q     <= rdat.tbl0;
          lvl_q   <= lvl_q + LVL_W'(1);
          state_q <= S_Q_LIFT;
        end
        S_Q_CMP: begin
          anc_q <= x_q;
          lvl_q <= LVL_CNT;
          state_q <= (x_q == y_q) ? S_Q_ANC : S_Q_DESC;
        end
        S_Q_DESC: begin
          state_q <= S_Q_DESCW;
        end
        S_Q_DESCW: begin
          if (rdat.tbl0 != rdat.tbl1) begin
            x_q <= rdat.tbl0;
            y_q <= rdat.tbl1;
          end
          lvl_q <= lvl_q - LVL_W'(1);
          state_q <= (lvl_q == LVL_W'(1)) ? S_Q_FIN : S_Q_DESC;
        end
        S_Q_FIN: begin
          state_q <= S_Q_FINW;
        end
        S_Q_FINW: begin
          // parents differ: no common ancestor, report the null node
          anc_q   <= (rdat.tbl0 == rdat.tbl1) ? rdat.tbl0 : '0;
          state_q <= S_Q_ANC;
        end
        S_Q_ANC: begin
          state_q <= S_Q_OUT;
        end
        S_Q_OUT: begin
          res_q.ancestor <= anc_q;
          if (sum_q <= twice) begin
            res_q.distance <= '0;
          end else if (diff > SUM_W'(lcabl_pkg::DIST_MAX)) begin
            res_q.distance <= lcabl_pkg::DIST_MAX;
          end else begin
            res_q.distance <= diff[lcabl_pkg::DIST_W-1:0];
          end
          res_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/core/lcabl_store.sv
// Ancestor table and depth store with per-node valid bits.
module lcabl_store #(
  parameter int unsigned NODES  = lcabl_pkg::NODES_DEF,
  parameter int unsigned LEVELS = lcabl_pkg::LEVELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lcabl_pkg::lcabl_rd_t rd_i,
  input  lcabl_pkg::lcabl_wr_t wr_i,
  output lcabl_pkg::lcabl_rdata_t rdata_o
);

  localparam int unsigned NW     = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned AW     = NW + LW;
  localparam int unsigned TDEPTH = NODES * (1 << LW);

  logic [lcabl_pkg::NODE_W-1:0]  tbl_mem_q [TDEPTH];
  logic [lcabl_pkg::DEPTH_W-1:0] dep_mem_q [NODES];
  logic [NODES-1:0]              vld_q;

  logic [lcabl_pkg::NODE_W-1:0]  tbl0_q, tbl1_q;
  logic [lcabl_pkg::DEPTH_W-1:0] dep0_q, dep1_q;
  logic                          vt0_q, vt1_q, vd0_q, vd1_q;

  logic [AW-1:0] raddr0, raddr1, waddr;

  assign raddr0 = {NW'(rd_i.tbl_node0), LW'(rd_i.tbl_lvl)};
  assign raddr1 = {NW'(rd_i.tbl_node1), LW'(rd_i.tbl_lvl)};
  assign waddr  = {NW'(wr_i.tbl_node), LW'(wr_i.tbl_lvl)};

  // valid bits: an invalid node reads as all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.vld_set) begin
      vld_q[NW'(wr_i.vld_node)] <= 1'b1;
    end else if (wr_i.vld_clr) begin
      vld_q[NW'(wr_i.vld_node)] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.tbl_we) begin
      tbl_mem_q[waddr] <= wr_i.tbl_data;
    end
    tbl0_q <= tbl_mem_q[raddr0];
    tbl1_q <= tbl_mem_q[raddr1];
    vt0_q  <= vld_q[NW'(rd_i.tbl_node0)];
    vt1_q  <= vld_q[NW'(rd_i.tbl_node1)];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.dep_we) begin
      dep_mem_q[NW'(wr_i.dep_node)] <= wr_i.dep_data;
    end
    dep0_q <= dep_mem_q[NW'(rd_i.dep_node0)];
    dep1_q <= dep_mem_q[NW'(rd_i.dep_node1)];
    vd0_q  <= vld_q[NW'(rd_i.dep_node0)];
    vd1_q  <= vld_q[NW'(rd_i.dep_node1)];
  end

  assign rdata_o.tbl0 = vt0_q ? tbl0_q : '0;
  assign rdata_o.tbl1 = vt1_q ? tbl1_q : '0;
  assign rdata_o.dep0 = vd0_q ? dep0_q : '0;
  assign rdata_o.dep1 = vd1_q ? dep1_q : '0;

endmodule

>>> tb/sv/lca_checker.sv
// Checker for the LCA engine: predicts every query result and compares it.
module lca_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  lcabl_pkg::lca_req_t req_i,
  input  logic                res_valid_i,
  input  lcabl_pkg::lca_res_t res_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES   = lcabl_pkg::NODES_DEF;
  localparam int LEVELS  = lcabl_pkg::LEVELS_DEF;
  localparam int NODE_W  = lcabl_pkg::NODE_W;
  localparam int DEPTH_W = lcabl_pkg::DEPTH_W;
  localparam int DIST_W  = lcabl_pkg::DIST_W;

  // Shadow copy of the lifting table and the depth store
  logic [NODE_W-1:0]   lift_tbl   [NODES][LEVELS];
  logic [DEPTH_W-1:0]  node_depth [NODES];
  lcabl_pkg::lca_res_t lca_q [$];

  int unsigned errs;
  int unsigned n_checked;

  assign fail_count_o = errs;
  assign checked_o    = n_checked;

  function automatic int hop(input int node, input int lvl);
    if (node >= NODES || lvl >= LEVELS) return 0;
    return int'(lift_tbl[node][lvl]);
  endfunction

  function automatic int depth_at(input int node);
    return (node < NODES) ? int'(node_depth[node]) : 0;
  endfunction

  // Applies one transaction to the shadow state; returns 1 when it yields a result.
  function automatic bit lca_apply(input lcabl_pkg::lca_req_t r,
                                   output lcabl_pkg::lca_res_t res);
    int a, b, x, y, t, dt, anc, sum, twice, path_len, px, py, d;
    a   = int'(r.node_a);
    b   = int'(r.node_b);
    res = '0;
    if (r.mode == lcabl_pkg::MODE_ROOT) begin
      for (int l = 0; l < LEVELS; l++) lift_tbl[a][l] = NODE_W'(a);
      node_depth[a] = DEPTH_W'(1);
      return 1'b0;
    end
    if (r.mode == lcabl_pkg::MODE_ATTACH) begin
      d = depth_at(b) + 1;
      node_depth[a] = (d > int'(lcabl_pkg::DEPTH_MAX)) ? lcabl_pkg::DEPTH_MAX
                                                       : DEPTH_W'(d);
      lift_tbl[a][0] = NODE_W'(b);
      for (int l = 1; l < LEVELS; l++) lift_tbl[a][l] = NODE_W'(hop(hop(a, l - 1), l - 1));
      return 1'b0;
    end
    if (r.mode == lcabl_pkg::MODE_CLEAR) begin
      for (int l = 0; l < LEVELS; l++) lift_tbl[a][l] = '0;
      node_depth[a] = '0;
      return 1'b0;
    end
    // query: lift the deeper node, then descend level by level
    x = a;
    y = b;
    if (depth_at(x) < depth_at(y)) begin
      t = x;
      x = y;
      y = t;
    end
    dt = depth_at(x) - depth_at(y);
    for (int l = 0; l < LEVELS; l++) if ((dt >> l) & 1) x = hop(x, l);
    if (x == y) begin
      anc = x;
    end else begin
      for (int l = LEVELS - 1; l >= 0; l--) begin
        px = hop(x, l);
        py = hop(y, l);
        if (px != py) begin
          x = px;
          y = py;
        end
      end
      if (x == y) anc = x;
      else if (hop(x, 0) == hop(y, 0)) anc = hop(x, 0);
      else anc = 0;
    end
    sum      = depth_at(a) + depth_at(b);
    twice    = 2 * depth_at(anc);
    path_len = (sum > twice) ? sum - twice : 0;
    if (path_len > int'(lcabl_pkg::DIST_MAX)) path_len = int'(lcabl_pkg::DIST_MAX);
    res.ancestor = NODE_W'(anc);
    res.distance = DIST_W'(path_len);
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lcabl_pkg::lca_res_t want, got;
    if (!rst_ni) begin
      for (int n = 0; n < NODES; n++) begin
        node_depth[n] = '0;
        for (int l = 0; l < LEVELS; l++) lift_tbl[n][l] = '0;
      end
      lca_q.delete();
      errs      = 0;
      n_checked = 0;
      pending_o = 0;
    end else begin
      // retire the result first; it always belongs to an older transaction
      if (res_valid_i) begin
        if (lca_q.size() == 0) begin
          if (errs < 10)
            $display("unexpected result: ancestor %0d distance %0d",
                     res_i.ancestor, res_i.distance);
          errs++;
        end else begin
          want = lca_q.pop_front();
          n_checked++;
          if (res_i.ancestor !== want.ancestor || res_i.distance !== want.distance) begin
            if (errs < 10)
              $display("mismatch on result %0d: ancestor exp %0d got %0d, %s %0d got %0d",
                       n_checked, want.ancestor, res_i.ancestor, "distance exp",
                       want.distance, res_i.distance);
            errs++;
          end
        end
      end
      if (start_i && !busy_i) begin
        if (lca_apply(req_i, got)) lca_q.push_back(got);
      end
      pending_o = lca_q.size();
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top: stimulus, idle phases and verdict for the LCA engine.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES  = lcabl_pkg::NODES_DEF;
  localparam int NODE_W = lcabl_pkg::NODE_W;
  localparam int REQ_W  = $bits(lcabl_pkg::lca_req_t);

  // Cycles without any accepted transaction or result before giving up.
  // Worst case between events is the longest sender gap plus the longest query.
  localparam int unsigned STALL_LIMIT = 2000;
  // Settle time after the last drain, above the longest query
  localparam int unsigned DRAIN_CYCLES = 40;
  // Transactions per idle phase
  localparam int unsigned PHASE_ITEMS  = 440;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                start  = 1'b0;
  lcabl_pkg::lca_req_t req_i  = '0;
  logic                busy;
  logic                res_valid_o;
  lcabl_pkg::lca_res_t res_o;

  int unsigned fail_count, pending, checked;
  int unsigned sent;
  int          gap_pct;
  // Nodes the stimulus believes are attached to some tree
  logic [NODES-1:0] live = '0;

  lca_binary_lifting_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  lca_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .res_valid_i  (res_valid_o),
    .res_i        (res_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: any accepted transaction or result restarts the count.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || res_valid_o) quiet = 0;
      else quiet++;
    end
    $display("timeout: no progress for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic lcabl_pkg::lca_req_t mk(input lcabl_pkg::mode_e m, input int a,
                                             input int b);
    lcabl_pkg::lca_req_t r;
    r.mode   = m;
    r.node_a = NODE_W'(a);
    r.node_b = NODE_W'(b);
    return r;
  endfunction

  // Random node that is (or is not) in the forest; any node if none qualifies.
  function automatic int pick_node(input bit want_live);
    int pool [$];
    for (int n = 0; n < NODES; n++) if (live[n] == want_live) pool.push_back(n);
    if (pool.size() == 0) return int'(NODE_W'($urandom));
    return pool[$urandom_range(pool.size() - 1)];
  endfunction

  // One transaction: optional idle gap (random junk on the bus while start is
  // low), then hold start until the engine takes it at a not-busy edge.
  task automatic issue(input lcabl_pkg::lca_req_t r);
    int               gap;
    logic [REQ_W-1:0] junk;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < gap_pct) gap++;
    repeat (gap) begin
      @(negedge clk_i);
      junk = REQ_W'($urandom);
      start <= 1'b0;
      req_i <= junk;
    end
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    sent++;
    case (r.mode)
      lcabl_pkg::MODE_ROOT, lcabl_pkg::MODE_ATTACH: live[r.node_a] = 1'b1;
      lcabl_pkg::MODE_CLEAR:                        live[r.node_a] = 1'b0;
      default: ;
    endcase
  endtask

  // Sender holds off until the engine is idle and every result is in.
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
  endtask

  // Mostly well-formed forest growth and queries between live nodes;
  // the rest is raw noise that may re-parent nodes or touch dead ones.
  task automatic random_item();
    int               kind, len, a, b;
    logic [REQ_W-1:0] raw;
    kind = $urandom_range(99);
    if (kind < 5) begin
      issue(mk(lcabl_pkg::MODE_ROOT, pick_node(1'b0), $urandom));
    end else if (kind < 38) begin
      if (&live) issue(mk(lcabl_pkg::MODE_CLEAR, pick_node(1'b1), $urandom));
      else issue(mk(lcabl_pkg::MODE_ATTACH, pick_node(1'b0), pick_node(1'b1)));
    end else if (kind < 70) begin
      issue(mk(lcabl_pkg::MODE_QUERY, pick_node(1'b1), pick_node(1'b1)));
    end else if (kind < 78) begin
      issue(mk(lcabl_pkg::MODE_CLEAR, pick_node(1'b1), $urandom));
    end else if (kind < 84) begin
      // deep chain: each new node hangs under the previous one
      len = $urandom_range(4, 12);
      b   = pick_node(1'b1);
      repeat (len) begin
        a = pick_node(1'b0);
        issue(mk(lcabl_pkg::MODE_ATTACH, a, b));
        b = a;
      end
    end else begin
      raw = REQ_W'($urandom);
      issue(lcabl_pkg::lca_req_t'(raw));
    end
  endtask

  initial begin
    int          phase_pct [3];
    int unsigned phase_start;
    int          n_calls;
    // sender idle share per phase; the receiver cannot stall, so the
    // receiver-only phase collapses into the no-idle one
    phase_pct = '{0, 70, 32};
    sent      = 0;
    gap_pct   = 0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty forest, a small tree, extremes, a second tree,
    // orphan parent, clearing a node with children, the null node.
    issue(mk(lcabl_pkg::MODE_QUERY, 0, 0));       // null node against itself
    issue(mk(lcabl_pkg::MODE_ROOT, 1, 0));
    issue(mk(lcabl_pkg::MODE_ATTACH, 2, 1));
    issue(mk(lcabl_pkg::MODE_ATTACH, 3, 1));
    issue(mk(lcabl_pkg::MODE_ATTACH, 4, 2));
    issue(mk(lcabl_pkg::MODE_ATTACH, 5, 4));
    issue(mk(lcabl_pkg::MODE_QUERY, 5, 3));       // lift then step to shared parent
    issue(mk(lcabl_pkg::MODE_QUERY, 4, 5));       // one node is ancestor of the other
    issue(mk(lcabl_pkg::MODE_QUERY, 1, 1));
    issue(mk(lcabl_pkg::MODE_ROOT, 63, 63));
    issue(mk(lcabl_pkg::MODE_ATTACH, 62, 63));
    issue(mk(lcabl_pkg::MODE_QUERY, 62, 5));      // separate trees: no common ancestor
    issue(mk(lcabl_pkg::MODE_ATTACH, 10, 20));    // parent never placed in a tree
    issue(mk(lcabl_pkg::MODE_QUERY, 10, 63));
    issue(mk(lcabl_pkg::MODE_CLEAR, 2, 0));       // children of 2 keep stale entries
    issue(mk(lcabl_pkg::MODE_QUERY, 5, 3));
    issue(mk(lcabl_pkg::MODE_ATTACH, 0, 63));     // write into the null slot
    issue(mk(lcabl_pkg::MODE_QUERY, 0, 62));
    issue(mk(lcabl_pkg::MODE_QUERY, 63, 63));
    issue(mk(lcabl_pkg::MODE_CLEAR, 0, 0));
    issue(mk(lcabl_pkg::MODE_QUERY, 62, 0));
    drain();

    // Depth saturation: self-attach climbs one level per transaction up to
    // the cap, then two capped nodes give a clamped distance.
    repeat (130) issue(mk(lcabl_pkg::MODE_ATTACH, 40, 40));
    repeat (130) issue(mk(lcabl_pkg::MODE_ATTACH, 41, 41));
    issue(mk(lcabl_pkg::MODE_QUERY, 40, 41));
    issue(mk(lcabl_pkg::MODE_ATTACH, 42, 40));    // saturates again at the cap
    issue(mk(lcabl_pkg::MODE_QUERY, 42, 1));
    issue(mk(lcabl_pkg::MODE_QUERY, 5, 40));
    drain();

    foreach (phase_pct[p]) begin
      phase_start = sent;
      n_calls     = 0;
      while (sent - phase_start < PHASE_ITEMS) begin
        // stretches of 50 with no gaps at all, a quarter of the time
        if (n_calls % 50 == 0) gap_pct = ($urandom_range(3) == 0) ? 0 : phase_pct[p];
        random_item();
        n_calls++;
      end
      drain();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d transactions (directed, depth saturation, 3 idle phases)",
             sent);
    $display("compared %0d ancestor/distance results, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
